// ===== hdl/sitda_pkg.sv =====
// Package for the signed integer to decimal ASCII converter.
// Holds the shared constants and the double-dabble pipeline word type.
// No dependencies.
package sitda_pkg;

	localparam int BIN_W           = 32;
	localparam int NUM_DIGITS      = 10;
	localparam int BCD_W           = 4 * NUM_DIGITS;
	localparam int DD_W            = BCD_W + BIN_W;
	localparam int STEPS_PER_STAGE = 8;
	localparam int IDX_W           = 4;

	localparam logic [6:0] ASCII_ZERO  = 7'd48;
	localparam logic [6:0] ASCII_MINUS = 7'd45;

	// Double-dabble working word: BCD digits on top, remaining binary below.
	typedef struct packed {
		logic             neg;
		logic [DD_W-1:0]  dd;
	} dd_word_t;

endpackage

// ===== hdl/sitda_dabble.sv =====
// One combinational slice of the binary to BCD conversion: eight
// shift-and-add-3 steps. Depends on sitda_pkg.
module sitda_dabble (
	input  sitda_pkg::dd_word_t word_in,
	output sitda_pkg::dd_word_t word_out
);

	always_comb begin
		logic [sitda_pkg::DD_W-1:0] w;
		w = word_in.dd;
		for (int s = 0; s < sitda_pkg::STEPS_PER_STAGE; s++) begin
			for (int d = 0; d < sitda_pkg::NUM_DIGITS; d++) begin
				if (w[sitda_pkg::BIN_W + 4*d +: 4] >= 4'd5) begin
					w[sitda_pkg::BIN_W + 4*d +: 4] = w[sitda_pkg::BIN_W + 4*d +: 4] + 4'd3;
				end
			end
			w = {w[sitda_pkg::DD_W-2:0], 1'b0};
		end
		word_out.neg = word_in.neg;
		word_out.dd  = w;
	end

endmodule

// ===== hdl/signed_int_to_decimal_ascii.sv =====
// Top level of the signed integer to decimal ASCII converter.
// Depends on sitda_pkg and sitda_dabble.

// Each accepted 32-bit two's complement word comes out as its decimal text,
// one ASCII character per output word, most significant first, with last
// set on the final character. Negative values start with '-', the most
// negative value included; zero gives a single '0'; leading zeros are never
// sent. A number gives 1 to 11 characters, the sign included.
// The next number's first character follows the previous last character
// with no idle cycle between them when that number already waits in the
// last pipeline stage, and the character emitter at the end sets the
// sustained rate. Ahead of it sits a six-stage pipeline: the magnitude is
// formed, four stages of eight double-dabble steps each turn it into ten
// BCD digits, and a last stage finds the leading digit. The pipeline takes
// a new word in every cycle while it has room, so the next numbers are
// converted while the current text is still being sent.
// A stall on the output holds the character and backs up the pipeline
// without losing or repeating anything.
module signed_int_to_decimal_ascii (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [31:0] value,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [6:0]  character,
	output logic        last
);

	// Pipeline stage registers. Valid bits travel with each stage's word.
	sitda_pkg::dd_word_t word_s1, word_s2, word_s3, word_s4, word_s5;
	sitda_pkg::dd_word_t dab_s2, dab_s3, dab_s4, dab_s5;
	logic [sitda_pkg::BCD_W-1:0] bcd_s6;
	logic [sitda_pkg::IDX_W-1:0] top_s6;
	logic                        neg_s6;
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic ld_s1, ld_s2, ld_s3, ld_s4, ld_s5, ld_s6;

	// Character emitter registers.
	logic [sitda_pkg::BCD_W-1:0] digits_q;
	logic [sitda_pkg::IDX_W-1:0] idx_q;
	logic                        minus_q;
	logic                        busy_q;

	logic                        out_take;
	logic                        em_ready;
	logic [sitda_pkg::IDX_W-1:0] top_d;
	logic [3:0]                  cur_digit;

	// A stage loads when it is empty or its word moves on in this cycle.
	assign em_ready = !busy_q || (out_take && last);
	assign ld_s6    = !v_s6 || em_ready;
	assign ld_s5    = !v_s5 || ld_s6;
	assign ld_s4    = !v_s4 || ld_s5;
	assign ld_s3    = !v_s3 || ld_s4;
	assign ld_s2    = !v_s2 || ld_s3;
	assign ld_s1    = !v_s1 || ld_s2;
	assign in_stall = !ld_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			if (ld_s1) v_s1 <= in_valid;
			if (ld_s2) v_s2 <= v_s1;
			if (ld_s3) v_s3 <= v_s2;
			if (ld_s4) v_s4 <= v_s3;
			if (ld_s5) v_s5 <= v_s4;
			if (ld_s6) v_s6 <= v_s5;
		end
	end

	// Stage 1: sign and magnitude. Negation at 32 unsigned bits keeps the
	// most negative value intact as 2^31.
	always_ff @(posedge clk) begin
		if (ld_s1) begin
			word_s1.neg <= value[31];
			word_s1.dd  <= {{sitda_pkg::BCD_W{1'b0}},
				(value[31] ? (32'd0 - value) : value)};
		end
	end

	// Stages 2 to 5: eight double-dabble steps each, 32 in all.
	sitda_dabble u_dab2 (.word_in(word_s1), .word_out(dab_s2));
	sitda_dabble u_dab3 (.word_in(word_s2), .word_out(dab_s3));
	sitda_dabble u_dab4 (.word_in(word_s3), .word_out(dab_s4));
	sitda_dabble u_dab5 (.word_in(word_s4), .word_out(dab_s5));

	always_ff @(posedge clk) begin
		if (ld_s2) word_s2 <= dab_s2;
		if (ld_s3) word_s3 <= dab_s3;
		if (ld_s4) word_s4 <= dab_s4;
		if (ld_s5) word_s5 <= dab_s5;
	end

	// Stage 6: index of the leading nonzero digit, or digit zero when the
	// whole value is zero.
	always_comb begin
		top_d = '0;
		for (int d = 0; d < sitda_pkg::NUM_DIGITS; d++) begin
			if (word_s5.dd[sitda_pkg::BIN_W + 4*d +: 4] != 4'd0) begin
				top_d = sitda_pkg::IDX_W'(d);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ld_s6) begin
			bcd_s6 <= word_s5.dd[sitda_pkg::DD_W-1:sitda_pkg::BIN_W];
			top_s6 <= top_d;
			neg_s6 <= word_s5.neg;
		end
	end

	// Emitter: the output is driven from its registers, so a stalled
	// character holds. The minus sign goes first, then the digits from the
	// leading one down to digit zero, which carries last.
	always_comb begin
		cur_digit = 4'd0;
		for (int d = 0; d < sitda_pkg::NUM_DIGITS; d++) begin
			if (idx_q == sitda_pkg::IDX_W'(d)) begin
				cur_digit = digits_q[4*d +: 4];
			end
		end
	end

	assign out_valid = busy_q;
	assign character = minus_q ? sitda_pkg::ASCII_MINUS
		: (sitda_pkg::ASCII_ZERO + {3'b000, cur_digit});
	assign last      = !minus_q && (idx_q == '0);
	assign out_take  = busy_q && !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			minus_q <= 1'b0;
			idx_q   <= '0;
		end else begin
			if (em_ready) begin
				busy_q <= v_s6;
				if (v_s6) begin
					minus_q <= neg_s6;
					idx_q   <= top_s6;
				end
			end else if (out_take) begin
				if (minus_q) begin
					minus_q <= 1'b0;
				end else begin
					idx_q <= idx_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (em_ready && v_s6) begin
			digits_q <= bcd_s6;
		end
	end

endmodule
